### design/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge out of reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### design/lbp3_pkg.sv
// Shared types and constants of the 3x3 local binary pattern unit.
// Used by every module of the block; depends on nothing.
package lbp3_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 13;
  localparam int ROW_W      = 13;
  localparam int OROW_W     = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] lbp_code;
    logic             end_of_frame;
  } out_t;

  // Per-beat position info: whether a code is due, whether it closes the
  // frame, which window rows/columns lie inside the image, line buffer address.
  // Index 0 is the top row / left column, index 2 the bottom row / right column.
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [COL_W-1:0] addr;
  } pos_t;

endpackage

### design/lbp3_ctrl.sv
// Configuration registers and raster position counters of the LBP unit.
// Depends on lbp3_pkg for widths, register indexes and the pos_t struct.
module lbp3_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lbp3_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lbp3_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             accept,
  output lbp3_pkg::pos_t                   pos
);

  logic [lbp3_pkg::WCFG_W-1:0] width_r;
  logic [lbp3_pkg::HCFG_W-1:0] height_r;
  logic [lbp3_pkg::COL_W-1:0]  in_col_r,  in_col_nxt;
  logic [lbp3_pkg::ROW_W-1:0]  in_row_r,  in_row_nxt;
  logic [lbp3_pkg::COL_W-1:0]  out_col_r, out_col_nxt;
  logic [lbp3_pkg::OROW_W-1:0] out_row_r, out_row_nxt;

  logic [31:0]                 wsat, hsat;
  logic [lbp3_pkg::EW_W-1:0]   w_eff, col_inc, ocol_inc;
  logic [lbp3_pkg::HCFG_W-1:0] h_eff, orow_inc;
  logic                        col_wrap, ocol_end, orow_end;

  always_comb begin
    // Zero is taken as one, anything above the limits saturates.
    wsat = 32'(width_r);
    if (wsat == 32'd0) begin
      wsat = 32'd1;
    end else if (wsat > 32'(lbp3_pkg::MAX_WIDTH)) begin
      wsat = 32'(lbp3_pkg::MAX_WIDTH);
    end
    hsat = 32'(height_r);
    if (hsat == 32'd0) begin
      hsat = 32'd1;
    end else if (hsat > 32'(lbp3_pkg::HEIGHT_LIMIT)) begin
      hsat = 32'(lbp3_pkg::HEIGHT_LIMIT);
    end
    w_eff = wsat[lbp3_pkg::EW_W-1:0];
    h_eff = hsat[lbp3_pkg::HCFG_W-1:0];

    col_inc  = lbp3_pkg::EW_W'(in_col_r) + lbp3_pkg::EW_W'(1);
    col_wrap = (col_inc >= w_eff);
    ocol_inc = lbp3_pkg::EW_W'(out_col_r) + lbp3_pkg::EW_W'(1);
    orow_inc = lbp3_pkg::HCFG_W'(out_row_r) + lbp3_pkg::HCFG_W'(1);
    ocol_end = (ocol_inc >= w_eff);
    orow_end = (orow_inc >= h_eff);

    pos.emit = (in_row_r >= lbp3_pkg::ROW_W'(2)) ||
               ((in_row_r == lbp3_pkg::ROW_W'(1)) && (in_col_r != '0));
    pos.last = pos.emit && ocol_end && orow_end;
    // After a mid-frame shrink the code position can sit past the new limits,
    // so the upper row and left column are bounded on both sides.
    pos.row_ok[0] = (out_row_r != '0) && (lbp3_pkg::HCFG_W'(out_row_r) <= h_eff);
    pos.row_ok[1] = (lbp3_pkg::HCFG_W'(out_row_r) < h_eff);
    pos.row_ok[2] = !orow_end;
    pos.col_ok[0] = (out_col_r != '0) && (lbp3_pkg::EW_W'(out_col_r) <= w_eff);
    pos.col_ok[1] = (lbp3_pkg::EW_W'(out_col_r) < w_eff);
    pos.col_ok[2] = !ocol_end;
    pos.addr      = in_col_r;

    if (col_wrap) begin
      in_col_nxt = '0;
      in_row_nxt = (in_row_r != '1) ? in_row_r + lbp3_pkg::ROW_W'(1) : in_row_r;
    end else begin
      in_col_nxt = col_inc[lbp3_pkg::COL_W-1:0];
      in_row_nxt = in_row_r;
    end
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (pos.last) begin
      // The frame's last code puts every counter back to the frame start.
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (pos.emit) begin
      if (ocol_end) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + lbp3_pkg::OROW_W'(1);
      end else begin
        out_col_nxt = ocol_inc[lbp3_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= lbp3_pkg::WIDTH_RESET;
      height_r  <= lbp3_pkg::HEIGHT_RESET;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (cfg_we && (cfg_addr == lbp3_pkg::REG_IMAGE_WIDTH)) begin
        width_r <= cfg_wdata[lbp3_pkg::WCFG_W-1:0];
      end
      if (cfg_we && (cfg_addr == lbp3_pkg::REG_IMAGE_HEIGHT)) begin
        height_r <= cfg_wdata[lbp3_pkg::HCFG_W-1:0];
      end
      if (accept) begin
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
      end
    end
  end

endmodule

### design/lbp3_line_buf.sv
// The two line buffers of the LBP unit, one read and one write port each.
// Depends on lbp3_pkg for the depth and pixel width.
module lbp3_line_buf (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [lbp3_pkg::COL_W-1:0]  rd_addr,
  input  logic                        wr_en,
  input  logic [lbp3_pkg::COL_W-1:0]  wr_addr,
  input  logic [lbp3_pkg::PIX_W-1:0]  wr_upper,
  input  logic [lbp3_pkg::PIX_W-1:0]  wr_middle,
  output logic [lbp3_pkg::PIX_W-1:0]  rd_upper,
  output logic [lbp3_pkg::PIX_W-1:0]  rd_middle
);

  logic [lbp3_pkg::PIX_W-1:0] upper_mem  [lbp3_pkg::MAX_WIDTH];
  logic [lbp3_pkg::PIX_W-1:0] middle_mem [lbp3_pkg::MAX_WIDTH];
  logic [lbp3_pkg::PIX_W-1:0] rd_upper_r, rd_middle_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    // Read data holds while no read is issued, so a stalled stage keeps it.
    if (rd_en) begin
      rd_upper_r  <= upper_mem[rd_addr];
      rd_middle_r <= middle_mem[rd_addr];
    end
  end

  assign rd_upper  = rd_upper_r;
  assign rd_middle = rd_middle_r;

endmodule

### design/lbp3_window.sv
// 3x3 pixel window, pattern comparison and result register of the LBP unit.
// Depends on lbp3_pkg for pos_t, out_t and the pixel width.
module lbp3_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  lbp3_pkg::pos_t              pos,
  input  logic [lbp3_pkg::PIX_W-1:0]  up_val,
  input  logic [lbp3_pkg::PIX_W-1:0]  mid_val,
  input  logic [lbp3_pkg::PIX_W-1:0]  new_val,
  input  logic                        out_ready,
  output logic                        out_valid,
  output lbp3_pkg::out_t              out_data
);

  logic [lbp3_pkg::PIX_W-1:0] win_r [3][3];
  logic [lbp3_pkg::PIX_W-1:0] win_nxt [3][3];
  logic [lbp3_pkg::PIX_W-1:0] masked [3][3];
  logic [lbp3_pkg::PIX_W-1:0] ctr;
  logic [lbp3_pkg::PIX_W-1:0] code;
  logic                       out_valid_r;
  lbp3_pkg::out_t             out_data_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = up_val;
    win_nxt[1][2] = mid_val;
    win_nxt[2][2] = new_val;

    // Cells outside the image compare as zero; the centre is never masked.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        masked[r][c] = (pos.row_ok[r] && pos.col_ok[c]) ? win_nxt[r][c] : '0;
      end
    end
    ctr = win_nxt[1][1];

    code[7] = (masked[0][0] >= ctr);
    code[6] = (masked[0][1] >= ctr);
    code[5] = (masked[0][2] >= ctr);
    code[4] = (masked[1][2] >= ctr);
    code[3] = (masked[2][2] >= ctr);
    code[2] = (masked[2][1] >= ctr);
    code[1] = (masked[2][0] >= ctr);
    code[0] = (masked[1][0] >= ctr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        win_r <= win_nxt;
      end
      if (go && pos.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && pos.emit) begin
      out_data_r.lbp_code     <= code;
      out_data_r.end_of_frame <= pos.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/local_binary_pattern_3x3_unit.sv
// Top level of the 3x3 local binary pattern unit: handshakes and the stage
// between line buffer read and window update. Uses lbp3_pkg, lbp3_ctrl,
// lbp3_line_buf and lbp3_window.
//
//   port group | direction | handshake        | payload
//   in_        | input     | in_valid/in_ready | in_t: pixel, flush
//   out_       | output    | out_valid/out_ready | out_t: lbp_code, end_of_frame
//   cfg_       | input     | cfg_we, no wait  | cfg_addr, cfg_wdata
//
// One beat per clock is taken unless in_ready is low. A beat's line buffer read
// is issued when it is accepted, and when the middle stage moves on the window
// shifts and any code it causes lands in the result register.
// A code is due on the beat width+1 places after its own pixel.
// Synchronous active-low reset clears the counters, window and valid flags;
// the line buffers need no clearing. in_ready drops only while the result
// register is full and not taken and the middle stage already holds a beat.
module local_binary_pattern_3x3_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lbp3_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lbp3_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [lbp3_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lbp3_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                       accept, go;
  lbp3_pkg::pos_t             pos;
  logic                       s1_valid_r, s1_valid_nxt;
  lbp3_pkg::pos_t             s1_pos_r;
  logic [lbp3_pkg::PIX_W-1:0] s1_new_r;
  logic                       fwd_r;
  logic [lbp3_pkg::PIX_W-1:0] fwd_up_r, fwd_mid_r;
  logic [lbp3_pkg::PIX_W-1:0] rd_upper, rd_middle, up_val, mid_val;

  assign go       = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || go;
  assign accept   = in_valid && in_ready;

  // When a beat reads the address that the beat ahead of it writes at the
  // same edge (width of one), the read misses that write; take it directly.
  assign up_val  = fwd_r ? fwd_up_r  : rd_upper;
  assign mid_val = fwd_r ? fwd_mid_r : rd_middle;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r  <= pos;
      s1_new_r  <= in_data.flush ? '0 : in_data.pixel;
      fwd_r     <= go && (s1_pos_r.addr == pos.addr);
      fwd_up_r  <= mid_val;
      fwd_mid_r <= s1_new_r;
    end
  end

  lbp3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pos       (pos)
  );

  lbp3_line_buf u_line_buf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (pos.addr),
    .wr_en     (go),
    .wr_addr   (s1_pos_r.addr),
    .wr_upper  (mid_val),
    .wr_middle (s1_new_r),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  lbp3_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .pos       (s1_pos_r),
    .up_val    (up_val),
    .mid_val   (mid_val),
    .new_val   (s1_new_r),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### design/lbp3_checker.sv
// Port-level checks of the LBP unit, bound to its top level.
// Depends on lbp3_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module lbp3_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input lbp3_pkg::out_t                   out_data
);

  // A result that is not taken stays, unchanged.
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Input is refused only while the result register is full and stalled.
  `ASSERT_IMP(a_ready_only_on_stall, !in_ready, out_valid && !out_ready)

  // A fresh result follows an accepted input beat that passed through the middle stage.
  `ASSERT_IMP(a_out_from_beat, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind local_binary_pattern_3x3_unit lbp3_checker u_lbp3_checker (.*);

### tb/sv/local_binary_pattern_3x3_unit_tb.sv
// Self-checking testbench for local_binary_pattern_3x3_unit: directed table, then random frames.
// A behavioral line-buffer predictor in this module supplies the expected codes.
// Depends on lbp3_pkg and the RTL of the unit only.
module local_binary_pattern_3x3_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int REPORT_CAP  = 100;

  typedef enum logic [1:0] {ROW_CFG, ROW_BEAT, ROW_CHECKED} row_kind_t;

  // A beat row carries {pixel, flush} in the low bits of data.
  typedef struct packed {
    row_kind_t                       kind;
    logic [lbp3_pkg::CFG_ADDR_W-1:0] addr;
    logic [lbp3_pkg::CFG_DATA_W-1:0] data;
    lbp3_pkg::out_t                  code;
  } dir_row_t;

  localparam dir_row_t DIRECTED [23] = '{
    '{ROW_CFG,     lbp3_pkg::REG_IMAGE_WIDTH,  13'd0,               9'h000},
    '{ROW_CFG,     lbp3_pkg::REG_IMAGE_HEIGHT, 13'd0,               9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b0}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b1}, 9'h000},
    '{ROW_CHECKED, lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b1}, {8'hFF, 1'b1}},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'hFF, 1'b0}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b1}, 9'h000},
    '{ROW_CHECKED, lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b1}, {8'h00, 1'b1}},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h80, 1'b0}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h55, 1'b0}, 9'h000},
    '{ROW_CHECKED, lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'hAA, 1'b0}, {8'h00, 1'b1}},
    '{ROW_CFG,     lbp3_pkg::REG_IMAGE_WIDTH,  13'd3,               9'h000},
    '{ROW_CFG,     lbp3_pkg::REG_IMAGE_HEIGHT, 13'd2,               9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'hFF, 1'b0}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h3C, 1'b1}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h01, 1'b0}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b0}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h7F, 1'b0}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'hFE, 1'b0}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b1}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b1}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b1}, 9'h000},
    '{ROW_BEAT,    lbp3_pkg::REG_IMAGE_WIDTH,  {4'd0, 8'h00, 1'b1}, 9'h000}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  lbp3_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_ready;
  lbp3_pkg::out_t                  out_data;
  logic                            cfg_we;
  logic [lbp3_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [lbp3_pkg::CFG_DATA_W-1:0] cfg_wdata;

  local_binary_pattern_3x3_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: registers, line buffers, window and stream positions.
  logic [lbp3_pkg::WCFG_W-1:0] width_reg  = lbp3_pkg::WIDTH_RESET;
  logic [lbp3_pkg::HCFG_W-1:0] height_reg = lbp3_pkg::HEIGHT_RESET;
  bit   [7:0]        line_upper  [lbp3_pkg::MAX_WIDTH];
  bit   [7:0]        line_middle [lbp3_pkg::MAX_WIDTH];
  bit   [7:0]        lbp_window  [3][3];
  int                pix_col, pix_row, code_col, code_row;

  lbp3_pkg::out_t codes_due [$];
  int   mismatches    = 0;
  int   beats_sent    = 0;
  int   quiet_cycles  = 0;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;
  bit   hold_req      = 1'b0;
  int   hold_left     = 0;
  logic [7:0] pix_level = 8'd0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > lbp3_pkg::MAX_WIDTH) return lbp3_pkg::MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > lbp3_pkg::HEIGHT_LIMIT) return lbp3_pkg::HEIGHT_LIMIT;
    return int'(height_reg);
  endfunction

  function automatic bit frame_idle();
    return pix_col == 0 && pix_row == 0 && code_col == 0 && code_row == 0;
  endfunction

  // Cells that fall outside the image read as zero.
  function automatic logic [7:0] window_cell(input int wr, input int wc, input int w,
                                             input int h);
    int rr, cc;
    rr = code_row + wr - 1;
    cc = code_col + wc - 1;
    if (rr < 0 || rr >= h || cc < 0 || cc >= w) return 8'd0;
    return lbp_window[wr][wc];
  endfunction

  task automatic compute_lbp(input lbp3_pkg::in_t beat, output bit has_code,
                             output lbp3_pkg::out_t code);
    int         w, h, idx;
    bit         due, last;
    logic [7:0] fresh, ctr;
    w = eff_width();
    h = eff_height();
    fresh = beat.flush ? 8'd0 : beat.pixel;
    idx = (pix_col < lbp3_pkg::MAX_WIDTH) ? pix_col : lbp3_pkg::MAX_WIDTH - 1;
    due = (pix_row >= 2) || (pix_row == 1 && pix_col >= 1);
    for (int r = 0; r < 3; r++) begin
      lbp_window[r][0] = lbp_window[r][1];
      lbp_window[r][1] = lbp_window[r][2];
    end
    lbp_window[0][2] = line_upper[idx];
    lbp_window[1][2] = line_middle[idx];
    lbp_window[2][2] = fresh;
    line_upper[idx]  = line_middle[idx];
    line_middle[idx] = fresh;
    if (pix_col + 1 >= w) begin
      pix_col = 0;
      if (pix_row < 'h1FFF) pix_row++;
    end else begin
      pix_col++;
    end
    has_code = due;
    code = '0;
    if (due) begin
      ctr = lbp_window[1][1];
      code.lbp_code = {window_cell(0, 0, w, h) >= ctr, window_cell(0, 1, w, h) >= ctr,
                       window_cell(0, 2, w, h) >= ctr, window_cell(1, 2, w, h) >= ctr,
                       window_cell(2, 2, w, h) >= ctr, window_cell(2, 1, w, h) >= ctr,
                       window_cell(2, 0, w, h) >= ctr, window_cell(1, 0, w, h) >= ctr};
      last = (code_row + 1 >= h) && (code_col + 1 >= w);
      code.end_of_frame = last;
      if (last) begin
        code_col = 0;
        code_row = 0;
        pix_col  = 0;
        pix_row  = 0;
      end else if (code_col + 1 >= w) begin
        code_col = 0;
        code_row = (code_row + 1) & 'hFFF;
      end else begin
        code_col++;
      end
    end
  endtask

  // Offers one beat, holds it until taken, then records what it should produce.
  task automatic send_beat(input lbp3_pkg::in_t beat, input bit typed,
                           input lbp3_pkg::out_t typed_code);
    bit             has_code;
    lbp3_pkg::out_t code;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = beat;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    compute_lbp(beat, has_code, code);
    if (typed) codes_due.push_back(typed_code);
    else if (has_code) codes_due.push_back(code);
  endtask

  // Stops offering beats until every code is back and the pipeline has emptied.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (codes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lbp3_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [lbp3_pkg::CFG_DATA_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = value;
    if (addr == lbp3_pkg::REG_IMAGE_WIDTH) width_reg = value[lbp3_pkg::WCFG_W-1:0];
    else height_reg = value[lbp3_pkg::HCFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Half the pixels sit close to a per-frame level so that ties with the centre are common.
  function automatic lbp3_pkg::in_t frame_pixel();
    lbp3_pkg::in_t beat;
    beat.flush = ($urandom_range(19) == 0);
    if ($urandom_range(1) == 1) beat.pixel = 8'($urandom_range(255));
    else beat.pixel = 8'(pix_level + $urandom_range(2) - 1);
    return beat;
  endfunction

  function automatic lbp3_pkg::in_t drain_beat();
    lbp3_pkg::in_t beat;
    beat.flush = ($urandom_range(4) != 0);
    beat.pixel = 8'($urandom_range(255));
    return beat;
  endfunction

  task automatic run_frame(input logic [lbp3_pkg::CFG_DATA_W-1:0] wval,
                           input logic [lbp3_pkg::CFG_DATA_W-1:0] hval, input bit broken);
    int w, h, cut;
    write_reg(lbp3_pkg::REG_IMAGE_WIDTH, wval);
    write_reg(lbp3_pkg::REG_IMAGE_HEIGHT, hval);
    w = eff_width();
    h = eff_height();
    pix_level = 8'($urandom_range(255));
    cut = broken ? int'($urandom_range(w * h - 1)) : w * h;
    for (int i = 0; i < cut; i++) send_beat(frame_pixel(), 1'b0, '0);
    if (broken) begin
      // The width only shrinks mid-frame: a wider row would read line buffer
      // columns that were never written.
      write_reg(lbp3_pkg::REG_IMAGE_WIDTH, 13'($urandom_range(1, eff_width())));
      write_reg(lbp3_pkg::REG_IMAGE_HEIGHT, 13'($urandom_range(1, 8)));
      while (!frame_idle())
        send_beat(($urandom_range(1) == 1) ? frame_pixel() : drain_beat(), 1'b0, '0);
    end else begin
      for (int i = 0; i < w + 1; i++) send_beat(drain_beat(), 1'b0, '0);
    end
  endtask

  task automatic random_phase(input int in_pct, input int out_pct, input int beats);
    int stop;
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    stop = beats_sent + beats;
    while (beats_sent < stop)
      run_frame(13'(($urandom_range(3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12)),
                13'($urandom_range(1, 6)), $urandom_range(6) == 0);
  endtask

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    lbp3_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (codes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected code beat, expected none, actual code %02h eof %0b",
                   $time, out_data.lbp_code, out_data.end_of_frame);
      end else begin
        want = codes_due.pop_front();
        if (out_data.lbp_code !== want.lbp_code) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: lbp_code mismatch, expected %02h, actual %02h",
                     $time, want.lbp_code, out_data.lbp_code);
        end
        if (out_data.end_of_frame !== want.end_of_frame) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: end_of_frame mismatch, expected %0b, actual %0b",
                     $time, want.end_of_frame, out_data.end_of_frame);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        write_reg(DIRECTED[i].addr, DIRECTED[i].data);
      end else begin
        send_beat(lbp3_pkg::in_t'(DIRECTED[i].data[8:0]), DIRECTED[i].kind == ROW_CHECKED,
                  DIRECTED[i].code);
      end
    end

    // Long result hold-off while the sender keeps pushing, so the input backs up.
    // This frame is as wide as the widest random frame, so it also fills every
    // line buffer column that later frames can read.
    drain_results();
    hold_req = 1'b1;
    run_frame(13'd40, 13'd2, 1'b0);

    random_phase(0, 0, 40);
    random_phase(48, 0, 40);
    random_phase(0, 48, 40);
    random_phase(19, 19, 40);

    drain_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
